@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of this block.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/bsh_pkg.sv @@
// Shared types, constants and helper functions for the battery status block.
// No dependencies; used by bsh_tracker and the top level.
package bsh_pkg;

    localparam int STAGE_COUNT = 5;
    localparam int ADC_BITS    = 12;
    localparam int STAGE_W     = 3;
    localparam int PCT_W       = 7;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 12;
    localparam int PERIOD_W    = 16;
    localparam int TABLE_ROWS  = 5;
    localparam int ROW_W       = 3;

    typedef logic [ADC_BITS-1:0] t_adc;
    typedef logic [STAGE_W-1:0]  t_stage;

    // Status machine states
    typedef enum logic [1:0] {
        MODE_OK  = 2'd0,
        MODE_LOW = 2'd1,
        MODE_CHG = 2'd2
    } t_mode;

    // Reported status codes
    localparam logic [1:0] STAT_CHG_FULL = 2'd3;

    // Register word addresses (paddr[3:2])
    localparam logic [1:0] REG_CHG_THR  = 2'd0;
    localparam logic [1:0] REG_LOW_HOLD = 2'd1;
    localparam logic [1:0] REG_SMP_PER  = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]    RST_CHG_THR  = 12'd910;
    localparam logic [TIME_W-1:0]   RST_LOW_HOLD = 32'd20000;
    localparam logic [PERIOD_W-1:0] RST_SMP_PER  = 16'd1500;
    localparam t_stage              RST_STAGE    = t_stage'(STAGE_COUNT - 1);

    // Hysteresis windows, half-scale volts at 12 bit over 3.6 V
    localparam t_adc WIN_LO [TABLE_ROWS] = '{12'd1962, 12'd2115, 12'd2149,
                                            12'd2195, 12'd2269};
    localparam t_adc WIN_HI [TABLE_ROWS] = '{12'd2132, 12'd2166, 12'd2212,
                                            12'd2286, 12'd2388};

    // One tracker step: rise above window, fall below it, hold inside
    function automatic t_stage stage_step(input t_stage stage, input t_adc adc);
        logic [ROW_W-1:0] row;
        t_stage           res;
        row = (stage < t_stage'(TABLE_ROWS)) ? ROW_W'(stage) : ROW_W'(TABLE_ROWS - 1);
        res = stage;
        if (adc > WIN_HI[row]) begin
            if (stage < t_stage'(STAGE_COUNT - 1)) begin
                res = stage + t_stage'(1);
            end
        end else if (adc < WIN_LO[row]) begin
            if (stage != '0) begin
                res = stage - t_stage'(1);
            end
        end
        return res;
    endfunction

    // Percent = (stage + 1) * 20, kept to 7 bits
    function automatic logic [PCT_W-1:0] stage_pct(input t_stage stage);
        logic [PCT_W-1:0] s1;
        s1 = PCT_W'(stage) + PCT_W'(1);
        return PCT_W'(s1 * PCT_W'(20));
    endfunction

endpackage

@@ rtl/core/battery_status_with_stage_hysteresis_top.sv @@
// Battery status monitor with staged hysteresis level tracking.
// An accepted input word goes to the input register, which feeds the state/result update
// into the result register. Throughput: one poll per cycle while the result is not stalled.
// A stalled result is held in the output register while one more poll waits.
// Reset (synchronous, active low): status ok, stage 4, first sample pending,
// all times zero, registers to their defaults. Depends on bsh_pkg, bsh_tracker.
`include "assert_macros.svh"

module battery_status_with_stage_hysteresis_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Poll input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // now_ms[31:0], charger_adc[43:32],
                                    // battery_adc[55:44], charge_full_pin[56]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // status[1:0], stop_pulse[2], stage[5:3],
                                    // percent[12:6]
);

    localparam int TW = bsh_pkg::TIME_W;

    // Configuration registers
    logic [bsh_pkg::THR_W-1:0]    r_chg_thr;
    logic [TW-1:0]                r_low_hold;
    logic [bsh_pkg::PERIOD_W-1:0] r_smp_per;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_thr  <= bsh_pkg::RST_CHG_THR;
            r_low_hold <= bsh_pkg::RST_LOW_HOLD;
            r_smp_per  <= bsh_pkg::RST_SMP_PER;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bsh_pkg::REG_CHG_THR:  r_chg_thr  <= pwdata[bsh_pkg::THR_W-1:0];
                bsh_pkg::REG_LOW_HOLD: r_low_hold <= pwdata;
                bsh_pkg::REG_SMP_PER:  r_smp_per  <= pwdata[bsh_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            bsh_pkg::REG_CHG_THR:  prdata = 32'(r_chg_thr);
            bsh_pkg::REG_LOW_HOLD: prdata = r_low_hold;
            bsh_pkg::REG_SMP_PER:  prdata = 32'(r_smp_per);
            default:               prdata = '0;
        endcase
    end

    // Input register and handshake
    logic            r_in_valid;
    logic [TW-1:0]   r_now;
    bsh_pkg::t_adc   r_chg_adc;
    bsh_pkg::t_adc   r_bat_adc;
    logic            r_full_pin;
    logic            r_out_valid;
    logic [15:0]     r_out_data;
    logic            adv;

    assign adv        = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_now      <= i_s_tdata[31:0];
            r_chg_adc  <= i_s_tdata[43:32];
            r_bat_adc  <= i_s_tdata[55:44];
            r_full_pin <= i_s_tdata[56];
        end
    end

    // Poll state
    bsh_pkg::t_mode  r_mode, n_mode;
    bsh_pkg::t_stage r_stage, n_stage, trk_stage;
    logic            r_first_pending, n_first_pending;
    bsh_pkg::t_adc   r_chg_level, n_chg_level;
    logic [TW-1:0]   r_last_smp, n_last_smp;
    logic [TW-1:0]   r_low_entry, n_low_entry;
    logic            r_stop_done, n_stop_done;

    logic            present;
    logic            hold_done;
    logic            smp_due;
    logic            pulse;
    logic [1:0]      status;

    assign present   = r_chg_level > bsh_pkg::t_adc'(r_chg_thr);
    assign hold_done = (r_now - r_low_entry) >= r_low_hold;
    assign smp_due   = (r_now - r_last_smp) >= TW'(r_smp_per);

    // Status machine: next state
    always_comb begin
        n_mode      = r_mode;
        n_stop_done = r_stop_done;
        n_low_entry = r_low_entry;
        case (r_mode)
            bsh_pkg::MODE_OK: begin
                if (present) begin
                    n_mode = bsh_pkg::MODE_CHG;
                end else if (r_stage == '0) begin
                    n_mode      = bsh_pkg::MODE_LOW;
                    n_stop_done = 1'b0;
                    n_low_entry = r_now;
                end
            end
            bsh_pkg::MODE_LOW: begin
                if (present) begin
                    n_mode = bsh_pkg::MODE_CHG;
                end else begin
                    if (!r_stop_done && hold_done) begin
                        n_stop_done = 1'b1;
                    end
                    if (r_stage != '0) begin
                        n_mode = bsh_pkg::MODE_OK;
                    end
                end
            end
            default: begin
                if (!present) begin
                    n_mode = bsh_pkg::MODE_OK;
                end
            end
        endcase
    end

    // Status machine: outputs
    always_comb begin
        case (r_mode)
            bsh_pkg::MODE_OK:  pulse = present;
            bsh_pkg::MODE_LOW: pulse = present | (~r_stop_done & hold_done);
            default:           pulse = 1'b0;
        endcase
        if (n_mode == bsh_pkg::MODE_CHG && !r_full_pin) begin
            status = bsh_pkg::STAT_CHG_FULL;
        end else begin
            status = 2'(n_mode);
        end
    end

    // Sampling: charger level store and stage tracker
    bsh_tracker u_tracker (
        .i_stage (r_stage),
        .i_adc   (r_bat_adc),
        .i_first (r_first_pending),
        .o_stage (trk_stage)
    );

    always_comb begin
        n_stage         = r_stage;
        n_first_pending = r_first_pending;
        n_chg_level     = r_chg_level;
        n_last_smp      = r_last_smp;
        if (smp_due) begin
            n_stage         = trk_stage;
            n_first_pending = 1'b0;
            n_chg_level     = r_chg_adc;
            n_last_smp      = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= bsh_pkg::MODE_OK;
            r_stage         <= bsh_pkg::RST_STAGE;
            r_first_pending <= 1'b1;
            r_chg_level     <= '0;
            r_last_smp      <= '0;
            r_low_entry     <= '0;
            r_stop_done     <= 1'b0;
        end else if (adv) begin
            r_mode          <= n_mode;
            r_stage         <= n_stage;
            r_first_pending <= n_first_pending;
            r_chg_level     <= n_chg_level;
            r_last_smp      <= n_last_smp;
            r_low_entry     <= n_low_entry;
            r_stop_done     <= n_stop_done;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {3'b000, bsh_pkg::stage_pct(n_stage), n_stage, pulse, status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    `ASSERT_NEXT(a_adv_gives_word, i_clk, i_rst_n, adv, r_out_valid)
    `ASSERT_NEXT(a_mode_holds, i_clk, i_rst_n, !adv, $stable(r_mode))
    `ASSERT_IMPL(a_first_on_adv, i_clk, i_rst_n, $fell(r_first_pending), $past(adv))

endmodule

@@ rtl/core/bsh_tracker.sv @@
// Battery stage tracker: next stage from current stage and one battery reading.
// Depends on bsh_pkg. The first sample steps STAGE_COUNT-1 times to settle.
module bsh_tracker (
    input  bsh_pkg::t_stage i_stage,
    input  bsh_pkg::t_adc   i_adc,
    input  logic            i_first,
    output bsh_pkg::t_stage o_stage
);

    // Chain of step units; only the first is live for ordinary samples
    always_comb begin
        bsh_pkg::t_stage s;
        s = i_stage;
        for (int i = 0; i < bsh_pkg::STAGE_COUNT - 1; i++) begin
            if (i == 0 || i_first) begin
                s = bsh_pkg::stage_step(s, i_adc);
            end
        end
        o_stage = s;
    end

endmodule

@@ verif/tb_battery_status_with_stage_hysteresis_top.sv @@
// Self-checking testbench for battery_status_with_stage_hysteresis_top.
// Drives polls over the input stream and register writes over APB, predicts each
// result word in-bench and checks it. Depends on bsh_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_battery_status_with_stage_hysteresis_top;
    import bsh_pkg::*;

    localparam int NUM_DIR         = 23;
    localparam int PHASE_POLLS     = 345;
    localparam int NUM_PHASES      = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 8;

    // One poll outcome: status, stop pulse, stage, percent
    typedef struct packed {
        logic [1:0] status;
        logic       pulse;
        t_stage     stage;
        logic [6:0] pct;
    } poll_res_t;

    // Directed poll plus optional hand-typed outcome
    typedef struct packed {
        logic [31:0] now;
        t_adc        chg;
        t_adc        bat;
        logic        full_n;
        logic        typed;
        poll_res_t   res;
    } poll_row_t;

    // Reset config: threshold 910, hold 20000 ms, sample period 1500 ms
    localparam poll_row_t DIR_ROWS [NUM_DIR] = '{
        // after reset: no sample until the period has run out
        '{32'd0,     12'd4095, 12'd4095, 1'b1, 1'b1, '{MODE_OK, 1'b0, 3'd4, 7'd100}},
        '{32'd1499,  12'd4095, 12'd0,    1'b0, 1'b1, '{MODE_OK, 1'b0, 3'd4, 7'd100}},
        // first sample settles the stage in one go, floor reading -> stage 0
        '{32'd1500,  12'd0,    12'd0,    1'b1, 1'b1, '{MODE_OK, 1'b0, 3'd0, 7'd20}},
        // enter low, then hold time just short of and exactly at the limit
        '{32'd1600,  12'd0,    12'd2200, 1'b1, 1'b0, '0},
        '{32'd21599, 12'd0,    12'd0,    1'b1, 1'b0, '0},
        '{32'd21600, 12'd0,    12'd0,    1'b1, 1'b0, '0},
        // one above the stage 0 window, then leave low
        '{32'd30000, 12'd0,    12'd2133, 1'b1, 1'b0, '0},
        '{32'd30001, 12'd0,    12'd0,    1'b0, 1'b0, '0},
        // charger one over threshold, reading on the window edge holds
        '{32'd40000, 12'd911,  12'd2166, 1'b1, 1'b0, '0},
        '{32'd40001, 12'd911,  12'd2166, 1'b0, 1'b0, '0},
        '{32'd40002, 12'd0,    12'd0,    1'b1, 1'b0, '0},
        // charger level equal to threshold is absent, one under window drops
        '{32'd41502, 12'd910,  12'd2114, 1'b1, 1'b0, '0},
        '{32'd41503, 12'd0,    12'd0,    1'b1, 1'b0, '0},
        '{32'd41504, 12'd0,    12'd0,    1'b1, 1'b0, '0},
        // time wraps through 2^32
        '{32'hFFFF_FFF0, 12'd4095, 12'd4095, 1'b0, 1'b0, '0},
        '{32'h0000_0010, 12'd0,    12'd4095, 1'b1, 1'b0, '0},
        '{32'd1487,  12'd0,    12'd4095, 1'b0, 1'b0, '0},
        '{32'd1488,  12'd0,    12'd2000, 1'b1, 1'b0, '0},
        // climb to the top stage and stay there, then step back down
        '{32'd3000,  12'd0,    12'd4095, 1'b1, 1'b0, '0},
        '{32'd4500,  12'd0,    12'd4095, 1'b1, 1'b0, '0},
        '{32'd6000,  12'd0,    12'd4095, 1'b1, 1'b0, '0},
        '{32'd7500,  12'd0,    12'd2268, 1'b1, 1'b0, '0},
        '{32'd9000,  12'd0,    12'd2269, 1'b1, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // now_ms[31:0], charger_adc[43:32],
                              // battery_adc[55:44], charge_full_pin[56]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // status[1:0], stop_pulse[2], stage[5:3],
                              // percent[12:6]

    battery_status_with_stage_hysteresis_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Predicted block state and register copies
    logic [THR_W-1:0]    cfg_thr    = RST_CHG_THR;
    logic [TIME_W-1:0]   cfg_hold   = RST_LOW_HOLD;
    logic [PERIOD_W-1:0] cfg_period = RST_SMP_PER;
    t_mode               mode_q     = MODE_OK;
    t_stage              level_q    = RST_STAGE;
    logic                settle_q   = 1'b1;
    t_adc                chg_lvl_q  = '0;
    logic [31:0]         last_smp_q = '0;
    logic [31:0]         low_ent_q  = '0;
    logic                stopped_q  = 1'b0;

    poll_res_t expected_results [$];

    int fail_count    = 0;
    int polls_sent    = 0;
    int results_seen  = 0;
    int idle_run      = 0;
    int settings_used = 1;
    int n_samples     = 0;
    int n_low         = 0;
    int n_stops       = 0;
    int n_chg         = 0;
    bit src_burst     = 1'b0;
    bit sink_burst    = 1'b0;

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // One hysteresis step of the stage tracker
    function automatic t_stage next_level(input t_stage lvl, input t_adc adc);
        int row;
        row = (int'(lvl) < TABLE_ROWS) ? int'(lvl) : TABLE_ROWS - 1;
        if (adc > WIN_HI[row]) begin
            return (int'(lvl) < STAGE_COUNT - 1) ? t_stage'(lvl + 1) : lvl;
        end
        if (adc < WIN_LO[row]) begin
            return (lvl != '0) ? t_stage'(lvl - 1) : lvl;
        end
        return lvl;
    endfunction

    // Status machine on old state, then sampling, then the reported word
    function automatic poll_res_t predict_poll(input logic [31:0] now, input t_adc chg,
                                               input t_adc bat, input logic full_n);
        poll_res_t r;
        logic      present;
        logic      pulse;
        present = chg_lvl_q > cfg_thr;
        pulse   = 1'b0;
        case (mode_q)
            MODE_OK: begin
                if (present) begin
                    mode_q = MODE_CHG;
                    pulse  = 1'b1;
                    n_chg++;
                end else if (level_q == '0) begin
                    mode_q    = MODE_LOW;
                    stopped_q = 1'b0;
                    low_ent_q = now;
                    n_low++;
                end
            end
            MODE_LOW: begin
                if (present) begin
                    mode_q = MODE_CHG;
                    pulse  = 1'b1;
                    n_chg++;
                end else begin
                    if (!stopped_q && (now - low_ent_q) >= cfg_hold) begin
                        stopped_q = 1'b1;
                        pulse     = 1'b1;
                        n_stops++;
                    end
                    if (level_q != '0) begin
                        mode_q = MODE_OK;
                    end
                end
            end
            default: begin
                if (!present) begin
                    mode_q = MODE_OK;
                end
            end
        endcase

        if ((now - last_smp_q) >= 32'(cfg_period)) begin
            last_smp_q = now;
            chg_lvl_q  = chg;
            n_samples++;
            if (settle_q) begin
                for (int i = 0; i < STAGE_COUNT - 1; i++) begin
                    level_q = next_level(level_q, bat);
                end
                settle_q = 1'b0;
            end else begin
                level_q = next_level(level_q, bat);
            end
        end

        r.status = mode_q;
        if (mode_q == MODE_CHG && !full_n) begin
            r.status = STAT_CHG_FULL;
        end
        r.pulse = pulse;
        r.stage = level_q;
        r.pct   = 7'((int'(level_q) + 1) * 20);
        return r;
    endfunction

    // Offer one poll word after a random gap; predict once it is taken
    task automatic send_poll(input logic [31:0] now, input t_adc chg, input t_adc bat,
                             input logic full_n, input logic typed, input poll_res_t typed_res);
        int        gap;
        poll_res_t pred;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, full_n, bat, chg, now};
        do @(posedge i_clk); while (!o_s_tready);
        pred = predict_poll(now, chg, bat, full_n);
        expected_results.push_back(typed ? typed_res : pred);
        polls_sent++;
        if (polls_sent % 64 == 0) begin
            src_burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    // APB write, then read back the same register
    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHG_THR:  cfg_thr    = value[THR_W-1:0];
            REG_LOW_HOLD: cfg_hold   = value;
            REG_SMP_PER:  cfg_period = value[PERIOD_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== value) begin
            note_failure($sformatf("register %0d read back %h, wrote %h", idx, got, value));
        end
    endtask

    // Compare one result word with the oldest prediction
    task automatic check_result(input logic [15:0] word);
        poll_res_t got;
        poll_res_t want;
        got = '{word[1:0], word[2], word[5:3], word[12:6]};
        if (expected_results.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing pending", results_seen));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.pulse !== want.pulse ||
            got.stage !== want.stage || got.pct !== want.pct) begin
            note_failure($sformatf(
                "result %0d: exp status=%0d stop=%0d stage=%0d pct=%0d, got %0d/%0d/%0d/%0d",
                results_seen, want.status, want.pulse, want.stage, want.pct,
                got.status, got.pulse, got.stage, got.pct));
        end
    endtask

    // Result sink: random stalls, bursts, and two long hold-offs to back up the block
    initial begin : result_sink
        int stall;
        i_m_tready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results_seen == 300 || results_seen == 900) begin
                stall = LONG_HOLD;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            check_result(o_m_tdata);
            results_seen++;
            if (results_seen % 64 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable)) begin
            idle_run <= 0;
        end else if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Timed out: no word moved for %0d cycles", idle_run);
            $display("FAILURE");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Main sequence: reset, directed table, then register phases with randomized polls
    initial begin : poll_source
        logic [31:0] clock_ms;
        logic [31:0] new_hold;
        logic [11:0] new_thr;
        logic [15:0] new_period;
        int          seg_left;
        int          bat_mode;
        int          chg_mode;
        t_adc        chg;
        t_adc        bat;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        seg_left   = 0;
        bat_mode   = 0;
        chg_mode   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[r]) begin
            send_poll(DIR_ROWS[r].now, DIR_ROWS[r].chg, DIR_ROWS[r].bat,
                      DIR_ROWS[r].full_n, DIR_ROWS[r].typed, DIR_ROWS[r].res);
        end

        for (int p = 1; p <= NUM_PHASES; p++) begin
            // drain before touching registers
            i_s_tvalid <= 1'b0;
            while (expected_results.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);

            case (p)
                1: begin  // all-zero extremes: every poll samples, instant stop
                    new_thr = 12'd0;       new_hold = 32'd0;          new_period = 16'd0;
                end
                2: begin  // all-max extremes: charger never present
                    new_thr = 12'd4095;    new_hold = 32'hFFFF_FFFF;  new_period = 16'hFFFF;
                end
                3: begin
                    new_thr    = 12'($urandom_range(0, 4095));
                    new_hold   = $urandom_range(0, 40000);
                    new_period = 16'($urandom_range(1, 5000));
                end
                default: begin
                    new_thr = 12'd910;     new_hold = 32'd6000;       new_period = 16'd1500;
                end
            endcase
            set_register(REG_CHG_THR,  {20'd0, new_thr});
            set_register(REG_LOW_HOLD, new_hold);
            set_register(REG_SMP_PER,  {16'd0, new_period});
            settings_used++;
            clock_ms = $urandom;

            for (int k = 0; k < PHASE_POLLS; k++) begin
                // segments hold a battery/charger regime so stages and modes move
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 40);
                    bat_mode = $urandom_range(0, 3);
                    chg_mode = $urandom_range(0, 2);
                end
                seg_left--;

                case ($urandom_range(0, 15))
                    0:       clock_ms = clock_ms + $urandom;
                    1:       clock_ms = clock_ms;
                    2:       clock_ms = clock_ms + 1;
                    default: clock_ms = clock_ms + $urandom_range(0, 2 * int'(cfg_period) + 1);
                endcase

                case (chg_mode)
                    0:       chg = t_adc'($urandom_range(0, int'(cfg_thr)));
                    1:       chg = (cfg_thr == 12'hFFF) ? 12'hFFF :
                                   t_adc'($urandom_range(int'(cfg_thr) + 1, 4095));
                    default: chg = t_adc'($urandom_range(0, 4095));
                endcase

                case (bat_mode)
                    0:       bat = t_adc'($urandom_range(0, int'(WIN_LO[0]) - 1));
                    1:       bat = t_adc'($urandom_range(int'(WIN_HI[TABLE_ROWS-1]) + 1, 4095));
                    2:       bat = t_adc'($urandom_range(int'(WIN_LO[0]) - 12,
                                                         int'(WIN_HI[TABLE_ROWS-1]) + 12));
                    default: bat = t_adc'($urandom_range(0, 4095));
                endcase

                send_poll(clock_ms, chg, bat, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d polls (%0d from the directed table) under %0d register settings; %0d results checked.",
                 polls_sent, NUM_DIR, settings_used, results_seen);
        $display("Predicted %0d samples, %0d low entries, %0d stop pulses, %0d charger entries.",
                 n_samples, n_low, n_stops, n_chg);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bsh_pkg.sv
rtl/core/bsh_tracker.sv
rtl/core/battery_status_with_stage_hysteresis_top.sv
verif/tb_battery_status_with_stage_hysteresis_top.sv
